FILE: rtl/pwrseq_pkg.sv
// Shared types, state codes and pin positions for the FPGA power sequencer.
package pwrseq_pkg;

    localparam int FSM_W      = 3;
    localparam int PIN_W      = 7;
    localparam int WDT_W      = 32;
    localparam int SUP_W      = 16;
    localparam int GOAL_W     = 2;
    localparam int BOOT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // state codes
    localparam logic [FSM_W-1:0] ST_ERROR  = 3'd0;
    localparam logic [FSM_W-1:0] ST_PDOWN  = 3'd1;
    localparam logic [FSM_W-1:0] ST_POFF   = 3'd2;
    localparam logic [FSM_W-1:0] ST_PUP    = 3'd3;
    localparam logic [FSM_W-1:0] ST_READY  = 3'd4;
    localparam logic [FSM_W-1:0] ST_CONFIG = 3'd5;
    localparam logic [FSM_W-1:0] ST_ACTIVE = 3'd6;

    // goal codes
    localparam logic [GOAL_W-1:0] GOAL_OFF    = 2'd0;
    localparam logic [GOAL_W-1:0] GOAL_RECONF = 2'd2;

    // pin bank bit positions
    localparam int PIN_MEM  = 0;
    localparam int PIN_B0   = 1;
    localparam int PIN_B1   = 2;
    localparam int PIN_PROG = 3;
    localparam int PIN_INIT = 4;
    localparam int PIN_PWR  = 5;
    localparam int PIN_I2C  = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WDT_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WDT_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_WAIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_WAIT     = 2'd3;

    localparam logic [WDT_W-1:0] RST_WDT_TIMEOUT = 32'd10000;
    localparam logic [SUP_W-1:0] RST_DOWN_WAIT   = 16'd150;
    localparam logic [SUP_W-1:0] RST_UP_WAIT     = 16'd3;

    typedef struct packed {
        logic             wdt_enable;
        logic [WDT_W-1:0] wdt_timeout;
        logic [SUP_W-1:0] down_wait;
        logic [SUP_W-1:0] up_wait;
    } t_cfg;

    typedef struct packed {
        logic [GOAL_W-1:0] goal;
        logic              cfg_memory;
        logic [BOOT_W-1:0] boot_select;
        logic              supply_level;
        logic              watchdog_level;
        logic              fpga_mem_select;
    } t_item;

    typedef struct packed {
        logic [FSM_W-1:0] fsm;
        logic             wdt_seen;
        logic [WDT_W-1:0] wdt_elapsed;
        logic             supply_det;
        logic [SUP_W-1:0] supply_elapsed;
        logic [PIN_W-1:0] pins;
    } t_state;

    typedef struct packed {
        logic [FSM_W-1:0] fsm_code;
        logic [PIN_W-1:0] pins;
        logic             i2c_accessible;
    } t_result;

endpackage

FILE: rtl/fpga_power_sequencer_watchdog.sv
// Top level of the FPGA power sequencer: input stage, state, config and result stage.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------------------
//  tick in  | in        | i_in_valid / o_in_ready  | goal, memory, boot, supply, wdog, fmem
//  result   | out       | o_out_valid / i_out_ready| state code and pin levels
//  config   | in        | i_cfg_we (no wait)       | i_cfg_index, i_cfg_data
//
//  A tick is registered in the input stage, then the sequencer state and the result register
//  update from it once the result stage is free: one tick per cycle sustained while results
//  are taken. The single state register update per cycle sets that rate.
//  Reset (synchronous, active low) puts the sequencer in the power-down wait with all pins
//  low and loads the default timeouts. A stalled result holds the input stage; ticks keep
//  flowing whenever the result is taken each cycle.
module fpga_power_sequencer_watchdog (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pwrseq_pkg::GOAL_W-1:0]       i_goal,
    input  logic                                i_cfg_memory,
    input  logic [pwrseq_pkg::BOOT_W-1:0]       i_boot_select,
    input  logic                                i_supply_level,
    input  logic                                i_watchdog_level,
    input  logic                                i_fpga_mem_select,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pwrseq_pkg::FSM_W-1:0]        o_fsm_code,
    output logic                                o_mem_select_pin,
    output logic                                o_boot0_pin,
    output logic                                o_boot1_pin,
    output logic                                o_program_low,
    output logic                                o_init_low,
    output logic                                o_power_enable,
    output logic                                o_i2c_released,
    output logic                                o_i2c_accessible,
    input  logic                                i_cfg_we,
    input  logic [pwrseq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwrseq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pwrseq_pkg::t_cfg    r_cfg;
    pwrseq_pkg::t_state  r_state;
    pwrseq_pkg::t_state  n_state;
    pwrseq_pkg::t_item   r_item;
    pwrseq_pkg::t_result r_out;
    pwrseq_pkg::t_result n_out;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                out_free;
    logic                advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wdt_enable  <= 1'b1;
            r_cfg.wdt_timeout <= pwrseq_pkg::RST_WDT_TIMEOUT;
            r_cfg.down_wait   <= pwrseq_pkg::RST_DOWN_WAIT;
            r_cfg.up_wait     <= pwrseq_pkg::RST_UP_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwrseq_pkg::CFG_WDT_ENABLE:  r_cfg.wdt_enable  <= i_cfg_data[0];
                pwrseq_pkg::CFG_WDT_TIMEOUT: r_cfg.wdt_timeout <= i_cfg_data;
                pwrseq_pkg::CFG_DOWN_WAIT:   r_cfg.down_wait   <= i_cfg_data[pwrseq_pkg::SUP_W-1:0];
                pwrseq_pkg::CFG_UP_WAIT:     r_cfg.up_wait     <= i_cfg_data[pwrseq_pkg::SUP_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.goal            <= i_goal;
            r_item.cfg_memory      <= i_cfg_memory;
            r_item.boot_select     <= i_boot_select;
            r_item.supply_level    <= i_supply_level;
            r_item.watchdog_level  <= i_watchdog_level;
            r_item.fpga_mem_select <= i_fpga_mem_select;
        end
    end

    pwrseq_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_next   (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.fsm            <= pwrseq_pkg::ST_PDOWN;
            r_state.wdt_seen       <= 1'b0;
            r_state.wdt_elapsed    <= '0;
            r_state.supply_det     <= 1'b0;
            r_state.supply_elapsed <= '0;
            r_state.pins           <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fsm_code       = r_out.fsm_code;
    assign o_mem_select_pin = r_out.pins[pwrseq_pkg::PIN_MEM];
    assign o_boot0_pin      = r_out.pins[pwrseq_pkg::PIN_B0];
    assign o_boot1_pin      = r_out.pins[pwrseq_pkg::PIN_B1];
    assign o_program_low    = r_out.pins[pwrseq_pkg::PIN_PROG];
    assign o_init_low       = r_out.pins[pwrseq_pkg::PIN_INIT];
    assign o_power_enable   = r_out.pins[pwrseq_pkg::PIN_PWR];
    assign o_i2c_released   = r_out.pins[pwrseq_pkg::PIN_I2C];
    assign o_i2c_accessible = r_out.i2c_accessible;

    // power is off whenever the sequencer is shutting down or sits unpowered
    a_unpowered_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.fsm == pwrseq_pkg::ST_PDOWN || r_state.fsm == pwrseq_pkg::ST_POFF)
        |-> !r_state.pins[pwrseq_pkg::PIN_PWR])
        else $error("power enabled while powered down");

    // config and active only run with power applied and I2C released
    a_run_powered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.fsm == pwrseq_pkg::ST_CONFIG || r_state.fsm == pwrseq_pkg::ST_ACTIVE)
        |-> (r_state.pins[pwrseq_pkg::PIN_PWR] && r_state.pins[pwrseq_pkg::PIN_I2C]))
        else $error("config/active without power or I2C release");

    // I2C release is sticky
    a_i2c_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pins[pwrseq_pkg::PIN_I2C] |=> r_state.pins[pwrseq_pkg::PIN_I2C])
        else $error("I2C release cleared");

    // a transaction moving out of the input stage always lands in the result stage
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost after stage advance");

    // state only changes when a transaction advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without a transaction");

endmodule

FILE: rtl/pwrseq_step.sv
// Next-state and result logic for one tick of the power sequencer.
module pwrseq_step (
    input  pwrseq_pkg::t_state  i_state,
    input  pwrseq_pkg::t_cfg    i_cfg,
    input  pwrseq_pkg::t_item   i_item,
    output pwrseq_pkg::t_state  o_next,
    output pwrseq_pkg::t_result o_result
);

    logic [pwrseq_pkg::SUP_W-1:0] sup_inc;
    logic [pwrseq_pkg::SUP_W-1:0] sup_wait;
    logic                         sup_want;
    logic                         sup_match;
    logic [pwrseq_pkg::WDT_W-1:0] wdt_inc;
    logic [pwrseq_pkg::WDT_W-1:0] wdt_nx;
    logic                         wdt_toggle;
    logic                         wdt_timeout;
    logic                         goal_off;

    always_comb begin
        sup_inc = i_state.supply_elapsed;
        if (i_state.supply_det && (i_state.supply_elapsed != {pwrseq_pkg::SUP_W{1'b1}})) begin
            sup_inc = i_state.supply_elapsed + 1'b1;
        end
        sup_want  = (i_state.fsm == pwrseq_pkg::ST_PUP);
        sup_wait  = sup_want ? i_cfg.up_wait : i_cfg.down_wait;
        sup_match = (i_item.supply_level == sup_want);

        wdt_inc = i_state.wdt_elapsed;
        if (i_state.wdt_elapsed != {pwrseq_pkg::WDT_W{1'b1}}) begin
            wdt_inc = i_state.wdt_elapsed + 1'b1;
        end
        wdt_toggle  = (i_item.watchdog_level != i_state.wdt_seen);
        wdt_nx      = wdt_toggle ? '0 : wdt_inc;
        wdt_timeout = i_cfg.wdt_enable && (wdt_nx > i_cfg.wdt_timeout);

        goal_off = (i_item.goal == pwrseq_pkg::GOAL_OFF);
    end

    always_comb begin
        o_next = i_state;
        case (i_state.fsm)
            pwrseq_pkg::ST_PDOWN, pwrseq_pkg::ST_PUP: begin
                o_next.supply_elapsed = sup_inc;
                if (sup_match) begin
                    if (!i_state.supply_det) begin
                        o_next.supply_det     = 1'b1;
                        o_next.supply_elapsed = '0;
                    end else if (sup_inc >= sup_wait) begin
                        o_next.supply_det = 1'b0;
                        o_next.fsm = sup_want ? pwrseq_pkg::ST_READY : pwrseq_pkg::ST_POFF;
                    end
                end
            end
            pwrseq_pkg::ST_POFF: begin
                if (!goal_off) begin
                    o_next.pins[pwrseq_pkg::PIN_INIT] = 1'b1;
                    o_next.pins[pwrseq_pkg::PIN_PWR]  = 1'b1;
                    o_next.fsm = pwrseq_pkg::ST_PUP;
                end
            end
            pwrseq_pkg::ST_READY: begin
                if (goal_off) begin
                    o_next.pins = i_state.pins & (pwrseq_pkg::PIN_W'(1) << pwrseq_pkg::PIN_I2C);
                    o_next.fsm  = pwrseq_pkg::ST_PDOWN;
                end else begin
                    o_next.pins = '0;
                    o_next.pins[pwrseq_pkg::PIN_PWR] = i_state.pins[pwrseq_pkg::PIN_PWR];
                    o_next.pins[pwrseq_pkg::PIN_I2C] = 1'b1;
                    o_next.pins[pwrseq_pkg::PIN_MEM] = i_item.cfg_memory;
                    o_next.pins[pwrseq_pkg::PIN_B0]  = i_item.boot_select[0];
                    o_next.pins[pwrseq_pkg::PIN_B1]  = i_item.boot_select[1];
                    o_next.wdt_seen    = 1'b0;
                    o_next.wdt_elapsed = '0;
                    o_next.fsm = pwrseq_pkg::ST_CONFIG;
                end
            end
            pwrseq_pkg::ST_CONFIG, pwrseq_pkg::ST_ACTIVE: begin
                o_next.wdt_seen    = i_item.watchdog_level;
                o_next.wdt_elapsed = wdt_nx;
                if (wdt_timeout) begin
                    o_next.fsm = pwrseq_pkg::ST_ERROR;
                end else if (goal_off) begin
                    o_next.pins = i_state.pins & (pwrseq_pkg::PIN_W'(1) << pwrseq_pkg::PIN_I2C);
                    o_next.fsm  = pwrseq_pkg::ST_PDOWN;
                end else if (i_state.fsm == pwrseq_pkg::ST_ACTIVE) begin
                    o_next.pins[pwrseq_pkg::PIN_MEM] = i_item.fpga_mem_select;
                end else if (i_item.watchdog_level) begin
                    o_next.fsm = pwrseq_pkg::ST_ACTIVE;
                end
            end
            default: begin
                // error, and the unused code which behaves the same
                o_next.fsm = pwrseq_pkg::ST_ERROR;
                if (goal_off) begin
                    o_next.pins = i_state.pins & (pwrseq_pkg::PIN_W'(1) << pwrseq_pkg::PIN_I2C);
                    o_next.fsm  = pwrseq_pkg::ST_PDOWN;
                end else if (i_item.goal == pwrseq_pkg::GOAL_RECONF) begin
                    o_next.pins[pwrseq_pkg::PIN_PROG] = 1'b1;
                    o_next.wdt_seen    = 1'b0;
                    o_next.wdt_elapsed = '0;
                    o_next.fsm = pwrseq_pkg::ST_READY;
                end
            end
        endcase
    end

    always_comb begin
        o_result.fsm_code       = o_next.fsm;
        o_result.pins           = o_next.pins;
        o_result.i2c_accessible = (o_next.fsm == pwrseq_pkg::ST_POFF)
                               || (o_next.fsm == pwrseq_pkg::ST_READY);
    end

endmodule

FILE: tb/pwrseq_tick_checker.sv
// Watches the tick and result channels, predicts sequencer state and pins, and compares.
module pwrseq_tick_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  pwrseq_pkg::t_item                   i_item,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  pwrseq_pkg::t_result                 i_result,
    input  logic                                i_cfg_we,
    input  logic [pwrseq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwrseq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    pwrseq_pkg::t_cfg    regs;
    pwrseq_pkg::t_state  seq;
    pwrseq_pkg::t_result pin_state_q[$];
    pwrseq_pkg::t_result oldest;
    int                  fail_count = 0;
    int                  pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // flag is left set when the supply goes back to the other level
    function automatic logic supply_settled(input logic level, input logic want_level,
                                            input logic [pwrseq_pkg::SUP_W-1:0] hold_ticks);
        if (seq.supply_det && seq.supply_elapsed != {pwrseq_pkg::SUP_W{1'b1}})
            seq.supply_elapsed = seq.supply_elapsed + 1'b1;
        if (level != want_level)
            return 1'b0;
        if (!seq.supply_det) begin
            seq.supply_det     = 1'b1;
            seq.supply_elapsed = '0;
            return 1'b0;
        end
        if (seq.supply_elapsed >= hold_ticks) begin
            seq.supply_det = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // toggle tracking runs even with the check disabled
    function automatic logic wdt_expired(input logic level);
        if (seq.wdt_elapsed != {pwrseq_pkg::WDT_W{1'b1}})
            seq.wdt_elapsed = seq.wdt_elapsed + 1'b1;
        if (level != seq.wdt_seen) begin
            seq.wdt_seen    = level;
            seq.wdt_elapsed = '0;
        end
        return regs.wdt_enable && (seq.wdt_elapsed > regs.wdt_timeout);
    endfunction

    // I2C release survives power down
    function automatic void enter_shutdown();
        logic released;
        released = seq.pins[pwrseq_pkg::PIN_I2C];
        seq.pins = '0;
        seq.pins[pwrseq_pkg::PIN_I2C] = released;
        seq.fsm = pwrseq_pkg::ST_PDOWN;
    endfunction

    function automatic pwrseq_pkg::t_result step_sequencer(input pwrseq_pkg::t_item it);
        pwrseq_pkg::t_result r;
        logic                pwr;
        case (seq.fsm)
            pwrseq_pkg::ST_PDOWN: begin
                if (supply_settled(it.supply_level, 1'b0, regs.down_wait))
                    seq.fsm = pwrseq_pkg::ST_POFF;
            end
            pwrseq_pkg::ST_POFF: begin
                if (it.goal != pwrseq_pkg::GOAL_OFF) begin
                    seq.pins[pwrseq_pkg::PIN_INIT] = 1'b1;
                    seq.pins[pwrseq_pkg::PIN_PWR]  = 1'b1;
                    seq.fsm = pwrseq_pkg::ST_PUP;
                end
            end
            pwrseq_pkg::ST_PUP: begin
                if (supply_settled(it.supply_level, 1'b1, regs.up_wait))
                    seq.fsm = pwrseq_pkg::ST_READY;
            end
            pwrseq_pkg::ST_READY: begin
                if (it.goal == pwrseq_pkg::GOAL_OFF) begin
                    enter_shutdown();
                end else begin
                    pwr = seq.pins[pwrseq_pkg::PIN_PWR];
                    seq.pins = '0;
                    seq.pins[pwrseq_pkg::PIN_PWR] = pwr;
                    seq.pins[pwrseq_pkg::PIN_I2C] = 1'b1;
                    seq.pins[pwrseq_pkg::PIN_MEM] = it.cfg_memory;
                    seq.pins[pwrseq_pkg::PIN_B0]  = it.boot_select[0];
                    seq.pins[pwrseq_pkg::PIN_B1]  = it.boot_select[1];
                    seq.wdt_seen    = 1'b0;
                    seq.wdt_elapsed = '0;
                    seq.fsm = pwrseq_pkg::ST_CONFIG;
                end
            end
            pwrseq_pkg::ST_CONFIG: begin
                if (wdt_expired(it.watchdog_level))
                    seq.fsm = pwrseq_pkg::ST_ERROR;
                else if (it.goal == pwrseq_pkg::GOAL_OFF)
                    enter_shutdown();
                else if (it.watchdog_level)
                    seq.fsm = pwrseq_pkg::ST_ACTIVE;
            end
            pwrseq_pkg::ST_ACTIVE: begin
                if (wdt_expired(it.watchdog_level))
                    seq.fsm = pwrseq_pkg::ST_ERROR;
                else if (it.goal == pwrseq_pkg::GOAL_OFF)
                    enter_shutdown();
                else
                    seq.pins[pwrseq_pkg::PIN_MEM] = it.fpga_mem_select;
            end
            default: begin
                // goal three acts like activate here: stay in error
                seq.fsm = pwrseq_pkg::ST_ERROR;
                if (it.goal == pwrseq_pkg::GOAL_OFF) begin
                    enter_shutdown();
                end else if (it.goal == pwrseq_pkg::GOAL_RECONF) begin
                    seq.pins[pwrseq_pkg::PIN_PROG] = 1'b1;
                    seq.wdt_seen    = 1'b0;
                    seq.wdt_elapsed = '0;
                    seq.fsm = pwrseq_pkg::ST_READY;
                end
            end
        endcase
        r.fsm_code       = seq.fsm;
        r.pins           = seq.pins;
        r.i2c_accessible = (seq.fsm == pwrseq_pkg::ST_POFF) || (seq.fsm == pwrseq_pkg::ST_READY);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.wdt_enable  = 1'b1;
            regs.wdt_timeout = pwrseq_pkg::RST_WDT_TIMEOUT;
            regs.down_wait   = pwrseq_pkg::RST_DOWN_WAIT;
            regs.up_wait     = pwrseq_pkg::RST_UP_WAIT;
            seq     = '0;
            seq.fsm = pwrseq_pkg::ST_PDOWN;
            pin_state_q.delete();
        end else begin
            // compare before pushing so a stray result never meets a fresh expectation
            if (i_out_valid && i_out_ready) begin
                if (pin_state_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with nothing expected: state %0d pins %b acc %b",
                                 $time, i_result.fsm_code, i_result.pins,
                                 i_result.i2c_accessible);
                end else begin
                    oldest = pin_state_q.pop_front();
                    if (i_result.fsm_code !== oldest.fsm_code || i_result.pins !== oldest.pins
                            || i_result.i2c_accessible !== oldest.i2c_accessible) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch: state exp %0d got %0d, ",
                                      "pins(i2c,pwr,init,prog,b1,b0,mem) exp %b got %b, ",
                                      "acc exp %b got %b"},
                                     $time, oldest.fsm_code, i_result.fsm_code,
                                     oldest.pins, i_result.pins,
                                     oldest.i2c_accessible, i_result.i2c_accessible);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pin_state_q.push_back(step_sequencer(i_item));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pwrseq_pkg::CFG_WDT_ENABLE:  regs.wdt_enable  = i_cfg_data[0];
                    pwrseq_pkg::CFG_WDT_TIMEOUT:
                        regs.wdt_timeout = i_cfg_data[pwrseq_pkg::WDT_W-1:0];
                    pwrseq_pkg::CFG_DOWN_WAIT:
                        regs.down_wait = i_cfg_data[pwrseq_pkg::SUP_W-1:0];
                    pwrseq_pkg::CFG_UP_WAIT:
                        regs.up_wait = i_cfg_data[pwrseq_pkg::SUP_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = pin_state_q.size();
    end

endmodule

FILE: tb/tb_fpga_power_sequencer_watchdog.sv
// Stimulus and verdict for the FPGA power sequencer, checked by pwrseq_tick_checker.
module tb_fpga_power_sequencer_watchdog;

    localparam int STALL_LIMIT = 3000;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic [pwrseq_pkg::GOAL_W-1:0]       goal = '0;
    logic                                cfg_memory = 1'b0;
    logic [pwrseq_pkg::BOOT_W-1:0]       boot_select = '0;
    logic                                supply = 1'b0;
    logic                                wdog = 1'b0;
    logic                                fmem = 1'b0;
    logic                                out_ready = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [pwrseq_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [pwrseq_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    logic                                in_ready;
    logic                                out_valid;
    logic [pwrseq_pkg::FSM_W-1:0]        fsm_code;
    logic                  mem_sel, boot0, boot1, prog_low, init_low, pwr_en, i2c_rel, i2c_acc;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int wd_span = 3;
    int down_len = 2;
    int up_len = 1;
    int quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fpga_power_sequencer_watchdog uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_goal            (goal),
        .i_cfg_memory      (cfg_memory),
        .i_boot_select     (boot_select),
        .i_supply_level    (supply),
        .i_watchdog_level  (wdog),
        .i_fpga_mem_select (fmem),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_fsm_code        (fsm_code),
        .o_mem_select_pin  (mem_sel),
        .o_boot0_pin       (boot0),
        .o_boot1_pin       (boot1),
        .o_program_low     (prog_low),
        .o_init_low        (init_low),
        .o_power_enable    (pwr_en),
        .o_i2c_released    (i2c_rel),
        .o_i2c_accessible  (i2c_acc),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    pwrseq_tick_checker pin_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_item       ({goal, cfg_memory, boot_select, supply, wdog, fmem}),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_result     ({fsm_code, {i2c_rel, pwr_en, init_low, prog_low, boot1, boot0, mem_sel},
                        i2c_acc}),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ends the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [pwrseq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pwrseq_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // waits until every result is out, then rewrites all four registers
    task automatic set_limits(input logic [31:0] en_word, input logic [31:0] timeout_word,
                              input logic [31:0] down_word, input logic [31:0] up_word);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        write_reg(pwrseq_pkg::CFG_WDT_ENABLE, en_word);
        write_reg(pwrseq_pkg::CFG_WDT_TIMEOUT, timeout_word);
        write_reg(pwrseq_pkg::CFG_DOWN_WAIT, down_word);
        write_reg(pwrseq_pkg::CFG_UP_WAIT, up_word);
        wd_span  = (timeout_word > 30) ? 30 : int'(timeout_word);
        down_len = (down_word[15:0] > 160) ? 160 : int'(down_word[15:0]);
        up_len   = (up_word[15:0] > 50) ? 50 : int'(up_word[15:0]);
    endtask

    task automatic tick(input logic [pwrseq_pkg::GOAL_W-1:0] g, input logic m,
                        input logic [pwrseq_pkg::BOOT_W-1:0] b,
                        input logic s, input logic w, input logic f);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        goal        <= g;
        cfg_memory  <= m;
        boot_select <= b;
        supply      <= s;
        wdog        <= w;
        fmem        <= f;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // mostly well-formed power cycles with random content, plus noise
    task automatic run_traffic(input int n_items);
        int          sent;
        int          kind;
        int          len;
        int          period;
        int          k;
        logic [1:0]  g;
        logic        lvl;
        sent = 0;
        lvl  = 1'b0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                len = down_len + $urandom_range(2, 6);
                for (k = 0; k < len; k++)
                    tick(pwrseq_pkg::GOAL_OFF, 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)), $urandom_range(0, 15) == 0,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (kind <= 6) begin
                g      = 2'($urandom_range(1, 3));
                period = $urandom_range(1, wd_span + 3);
                len    = up_len + $urandom_range(3, 40);
                for (k = 0; k < len; k++) begin
                    if (k % period == 0)
                        lvl = ~lvl;
                    tick(g, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         $urandom_range(0, 15) != 0, lvl, 1'($urandom_range(0, 1)));
                end
            end else if (kind == 7) begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    tick(pwrseq_pkg::GOAL_RECONF, 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (kind == 8) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                // starve the watchdog input
                len = wd_span + $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    tick(2'd1, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 1'b1, lvl,
                         1'($urandom_range(0, 1)));
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        set_limits(1, 3, 2, 1);
        // supply wait with a glitch that leaves the flag set
        tick(pwrseq_pkg::GOAL_OFF, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0);
        tick(pwrseq_pkg::GOAL_OFF, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        tick(pwrseq_pkg::GOAL_OFF, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0);
        tick(pwrseq_pkg::GOAL_OFF, 1'b1, 2'd3, 1'b1, 1'b1, 1'b1);
        tick(2'd3, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        tick(pwrseq_pkg::GOAL_RECONF, 1'b1, 2'd3, 1'b1, 1'b0, 1'b1);
        tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b1);
        tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0);
        tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        // no toggle until timeout
        repeat (4) tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b1);
        tick(2'd1, 1'b1, 2'd1, 1'b1, 1'b1, 1'b0);
        tick(2'd3, 1'b0, 2'd2, 1'b0, 1'b0, 1'b1);
        tick(pwrseq_pkg::GOAL_RECONF, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        repeat (4) tick(pwrseq_pkg::GOAL_OFF, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0);
        tick(2'd1, 1'b1, 2'd2, 1'b1, 1'b1, 1'b1);

        set_limits(1, 6, 3, 2);
        run_traffic(200);

        send_idle_pct = 59;
        set_limits(1, 0, 0, 0);
        run_traffic(150);

        // upper bits above each register's width must be dropped
        send_idle_pct = 0;
        stall_pct     = 59;
        set_limits(32'hFFFF_FFFE, 5, 32'h0001_0004, 3);
        run_traffic(150);

        send_idle_pct = 33;
        stall_pct     = 33;
        set_limits(1, 32'hFFFF_FFFF, 1, 32'h0000_FFFF);
        run_traffic(100);

        send_idle_pct = 0;
        stall_pct     = 0;
        set_limits(1, pwrseq_pkg::RST_WDT_TIMEOUT, 32'(pwrseq_pkg::RST_DOWN_WAIT),
                   32'(pwrseq_pkg::RST_UP_WAIT));
        run_traffic(200);

        send_idle_pct = 33;
        stall_pct     = 33;
        set_limits(1, 12, 2, 4);
        run_traffic(200);

        // long hold at the wrong level during the shutdown wait: the flag stays set
        send_idle_pct = 0;
        stall_pct     = 0;
        set_limits(1, 20, 32'h0000_FFFF, 0);
        repeat (4) tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
        repeat (2) tick(pwrseq_pkg::GOAL_OFF, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0);
        repeat (60)
            tick(pwrseq_pkg::GOAL_OFF, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (3) tick(pwrseq_pkg::GOAL_OFF, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0);
        repeat (3) tick(2'd1, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);

        stall_pct = 59;
        set_limits(0, 2, 5, 1);
        run_traffic(150);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
